// File: rtl/block_scaled_fp_dequantizer_top_macros.svh
// assertion macros for the dequantizer
`ifndef BLOCK_SCALED_FP_DEQUANTIZER_TOP_MACROS_SVH
`define BLOCK_SCALED_FP_DEQUANTIZER_TOP_MACROS_SVH
// implication checked on every clock, skipped in reset
`define BSD_ASSERT_IMPL(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BSD_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/bsfd_pkg.sv
// ----------------------------------------------------------------------------
// bsfd_pkg
// shared constants, types and element decode functions of the dequantizer
// ----------------------------------------------------------------------------
package bsfd_pkg;
	localparam int F8_BLOCK_ELEMS  = 128;
	localparam int FP4_BLOCK_ELEMS = 32;
	localparam int FP4_BLOCK_BYTES = FP4_BLOCK_ELEMS / 2;
	localparam int POS_W = $clog2(F8_BLOCK_ELEMS + 1);
	localparam int ROW_W = 21;

	localparam logic [1:0] MODE_BF16 = 2'd0;
	localparam logic [1:0] MODE_F8   = 2'd1;
	localparam logic [1:0] MODE_FP4  = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	// register byte addresses
	localparam logic [2:0] ADDR_MODE = 3'd0;
	localparam logic [2:0] ADDR_ROWS = 3'd4;

	localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
	localparam logic [31:0] INF_BITS  = 32'h7F800000;

	// element in normalized form: (-1)^neg * m * 2^k, m < 16
	typedef struct packed {
		logic       neg;
		logic [3:0] m;
		logic signed [5:0] k;
	} elem_t;

	typedef logic [3:0] fp4_mag_t [8];
	localparam fp4_mag_t FP4_MAG2 = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12};

	function automatic elem_t dec_e4m3(input logic [7:0] x);
		elem_t r;
		r.neg = x[7];
		if (x[6:0] == 7'h7f) begin
			r = '0;
		end else if (x[6:3] == 4'd0) begin
			r.m = {1'b0, x[2:0]};
			r.k = -6'sd9;
		end else begin
			r.m = {1'b1, x[2:0]};
			r.k = $signed({2'b00, x[6:3]}) - 6'sd10;
		end
		return r;
	endfunction

	function automatic elem_t dec_fp4(input logic [3:0] q);
		elem_t r;
		r.neg = q[3];
		r.m = FP4_MAG2[q[2:0]];
		r.k = -6'sd1;
		return r;
	endfunction
endpackage

// File: rtl/bsfd_lane.sv
// ----------------------------------------------------------------------------
// bsfd_lane
// multiplies one decoded element by the e8m0 scale, fp32 result
// ----------------------------------------------------------------------------
module bsfd_lane (
	input  bsfd_pkg::elem_t elem,
	input  logic [7:0]      scode,
	output logic [31:0]     result
);
	import bsfd_pkg::*;

	logic [31:0] sbit;
	logic signed [9:0] kk, e;
	logic [2:0] p;
	logic signed [9:0] sh;
	logic [22:0] frac;

	always_comb begin
		sbit = {elem.neg, 31'd0};
		kk = 10'(elem.k) + ((scode == 8'd0) ? -10'sd127 : ($signed({2'b00, scode}) - 10'sd127));
		if (elem.m[3]) p = 3'd3;
		else if (elem.m[2]) p = 3'd2;
		else if (elem.m[1]) p = 3'd1;
		else p = 3'd0;
		e = kk + 10'($signed({1'b0, p}));
		sh = kk + 10'sd149;
		frac = 23'({elem.m, 19'd0} >> p) ;
		frac = 23'(23'(elem.m) << (5'd23 - 5'(p)));
		if (scode == 8'hff) begin
			result = (elem.m == 4'd0) ? QNAN_BITS : (sbit | INF_BITS);
		end else if (elem.m == 4'd0) begin
			result = sbit;
		end else if (e > 10'sd127) begin
			result = sbit | INF_BITS;
		end else if (e >= -10'sd126) begin
			result = sbit | {1'b0, 8'(e + 10'sd127), frac};
		end else begin
			result = sbit | {9'd0, 23'(23'(elem.m) << 5'(sh))};
		end
	end
endmodule

// File: rtl/block_scaled_fp_dequantizer_top.sv
// ----------------------------------------------------------------------------
// block_scaled_fp_dequantizer_top
// bf16 / e4m3fn / mxfp4 row dequantizer to fp32 with apb configuration
// ----------------------------------------------------------------------------
// one input word per cycle while the output is not stalled, results in a single output
// register that also acts as the skid point: a new transaction is accepted
// whenever the output register is empty or is being emptied. two scaling
// lanes work side by side (low and high nibble in mxfp4, low lane alone in
// e4m3) and the merge stage packs them with count and row end. scale bytes
// and mode 3 produce no result. a mode or rows write restarts the row.
module block_scaled_fp_dequantizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] data_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value_lo,
	output logic [31:0] value_hi,
	output logic [1:0]  value_count,
	output logic        row_end
);
	import bsfd_pkg::*;
	`include "block_scaled_fp_dequantizer_top_macros.svh"

	logic [1:0]       mode_q;
	logic [ROW_W-1:0] rows_q;
	logic [7:0]       scale_q;
	logic [POS_W-1:0] pos_q;
	logic [ROW_W-1:0] prog_q;

	logic wr, acc, in_fire, last_byte, row_last, emit;
	logic [POS_W-1:0] per_block;
	elem_t e_lo, e_hi;
	logic [31:0] r_lo, r_hi, r_bf;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign in_ready = !out_valid || out_ready;
	assign in_fire = in_valid && in_ready;

	always_comb begin
		case (paddr)
			ADDR_MODE: prdata = {30'd0, mode_q};
			ADDR_ROWS: prdata = {11'd0, rows_q};
			default:   prdata = '0;
		endcase
	end

	// per-cycle decode and row bookkeeping
	always_comb begin
		per_block = (mode_q == MODE_F8) ? POS_W'(F8_BLOCK_ELEMS) : POS_W'(FP4_BLOCK_BYTES);
		last_byte = pos_q >= per_block;
		row_last = (22'(prog_q) + 22'd1) >= 22'(rows_q);
		acc = in_fire && mode_q != MODE_RSVD;
		emit = acc && (mode_q == MODE_BF16 || pos_q != '0);
		if (mode_q == MODE_F8) e_lo = dec_e4m3(data_word[7:0]);
		else e_lo = dec_fp4(data_word[3:0]);
		e_hi = dec_fp4(data_word[7:4]);
		r_bf = {data_word, 16'd0};
	end

	bsfd_lane u_lane_lo (.elem(e_lo), .scode(scale_q), .result(r_lo));
	bsfd_lane u_lane_hi (.elem(e_hi), .scode(scale_q), .result(r_hi));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BF16;
			rows_q <= ROW_W'(1);
			scale_q <= '0;
			pos_q <= '0;
			prog_q <= '0;
		end else if (wr && (paddr == ADDR_MODE || paddr == ADDR_ROWS)) begin
			if (paddr == ADDR_MODE) mode_q <= pwdata[1:0];
			else rows_q <= pwdata[ROW_W-1:0];
			pos_q <= '0;
			prog_q <= '0;
		end else if (acc) begin
			if (mode_q == MODE_BF16) begin
				prog_q <= row_last ? '0 : prog_q + ROW_W'(1);
			end else if (pos_q == '0) begin
				scale_q <= data_word[7:0];
				pos_q <= POS_W'(1);
			end else begin
				pos_q <= last_byte ? '0 : pos_q + POS_W'(1);
				if (last_byte) prog_q <= row_last ? '0 : prog_q + ROW_W'(1);
			end
		end
	end

	// merge stage: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && emit) begin
			case (mode_q)
				MODE_BF16: begin
					value_lo <= r_bf; value_hi <= '0; value_count <= 2'd1;
					row_end <= row_last;
				end
				MODE_F8: begin
					value_lo <= r_lo; value_hi <= '0; value_count <= 2'd1;
					row_end <= last_byte && row_last;
				end
				default: begin
					value_lo <= r_lo; value_hi <= r_hi; value_count <= 2'd2;
					row_end <= last_byte && row_last;
				end
			endcase
		end
	end

	`BSD_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value_lo), "result changed under stall")
	`BSD_ASSERT_IMPL(a_count_ok, clk, arst_n, out_valid, value_count == 2'd1 || value_count == 2'd2, "bad value count")
	`BSD_ASSERT_NEXT(a_scale_silent, clk, arst_n, in_fire && mode_q != MODE_BF16 && pos_q == '0, !out_valid || $stable(value_lo), "scale byte produced a result")
endmodule
